/* src/lookat_view_matrix_assert.svh */
// Assertion macros for the look-at view matrix checker.
`ifndef LOOKAT_VIEW_MATRIX_ASSERT_SVH
`define LOOKAT_VIEW_MATRIX_ASSERT_SVH
// Check a property on every clock edge outside reset.
`define LVM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lookat_view_matrix: property failed");
// Check a property on every clock edge, reset included.
`define LVM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lookat_view_matrix: property failed");
`endif

/* src/lvm_pkg.sv */
// Types, widths and helper functions for the look-at view matrix unit.
`timescale 1ns / 1ps
package lvm_pkg;

  // Fixed-point format of all vectors.
  localparam int FRAC_BITS = 16;
  localparam int unsigned ONE = 1 << FRAC_BITS;
  localparam int unsigned HALF = 1 << (FRAC_BITS - 1);

  // Tolerance register.
  localparam int TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  // Square root pipeline: 64-bit radicand, one result bit per stage.
  localparam int SQRT_W = 64;
  localparam int SQRT_STAGES = SQRT_W / 2;

  // Divider for normalizing: quotient never exceeds ONE.
  localparam int QW = FRAC_BITS + 1;
  localparam int NUM_W = 32 + FRAC_BITS + 1;

  // Unit vector component, signed.
  localparam int SW = QW + 1;
  // Cross product term and rounded up-vector component.
  localparam int PW = 2 * SW;
  localparam int UW = PW + 1 - FRAC_BITS;
  // Dot product accumulator.
  localparam int DOT_W = 66;

  // Cycles from an accepted start to the result strobe.
  localparam int LATENCY = 2 * SQRT_STAGES + 2 * QW + 14;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } lvm_in_t;

  typedef struct packed {
    logic signed [31:0] row0_col0;
    logic signed [31:0] row0_col1;
    logic signed [31:0] row0_col2;
    logic signed [31:0] row0_shift;
    logic signed [31:0] row1_col0;
    logic signed [31:0] row1_col1;
    logic signed [31:0] row1_col2;
    logic signed [31:0] row1_shift;
    logic signed [31:0] row2_col0;
    logic signed [31:0] row2_col1;
    logic signed [31:0] row2_col2;
    logic signed [31:0] row2_shift;
  } lvm_out_t;

  // Magnitude of a 32-bit two's complement value; the most negative maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Clamp a wide signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [DOT_W-1:0] v);
    logic signed [DOT_W-1:0] hi;
    logic signed [DOT_W-1:0] lo;
    hi = {{(DOT_W-31){1'b0}}, {31{1'b1}}};
    lo = {{(DOT_W-31){1'b1}}, {31{1'b0}}};
    if (v > hi) begin
      return 32'h7fff_ffff;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

/* src/lookat_view_matrix.sv */
// Look-at view matrix setup: camera position and direction in, three matrix rows out.
// Fully pipelined: one camera may start in every cycle (busy_o is high only in reset and
// the cycle after it), and its rows come out on res_o flagged by a one-cycle res_valid_o
// strobe that the receiver cannot hold off. The pipeline is two normalizations in series,
// each a 32-stage square-root pipeline followed by a 17-stage divider pipeline, plus
// 14 stages of setup, cross product and dot products. zero_tolerance must be written over
// the cfg channel only while no camera is in flight; the block does not enforce this.
`timescale 1ns / 1ps
module lookat_view_matrix import lvm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  lvm_in_t          in_i,
  output logic             res_valid_o,
  output lvm_out_t         res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [TOL_W-1:0] cfg_data_i
);

  // Stage times counted from the input register.
  localparam int T_A     = 1;
  localparam int T_C     = 3;
  localparam int T_LEN_S = T_C + SQRT_STAGES;
  localparam int T_E     = T_LEN_S + 1;
  localparam int T_G     = T_E + QW + 1;
  localparam int T_I     = T_G + 2;
  localparam int T_K     = T_I + 2;
  localparam int T_LEN_U = T_K + SQRT_STAGES;
  localparam int T_M     = T_LEN_U + 1;
  localparam int T_U     = T_M + QW + 1;
  localparam int L_NRM   = T_LEN_S - T_A;
  // Side and position land in stage U through its own register.
  localparam int L_S     = T_U - T_G - 1;
  localparam int L_FP    = T_U - T_A - 1;
  localparam int L_UM    = T_LEN_U - T_I;

  typedef struct packed {
    logic [2:0][31:0] sm;
    logic [2:0]       ss;
    logic [2:0][31:0] fm;
    logic [2:0]       fs;
  } nrm_t;

  typedef struct packed {
    logic [2:0] ss;
    logic [2:0] fs;
    logic       zs;
    logic       zf;
  } sflag_t;

  typedef struct packed {
    logic [2:0][UW-1:0] um;
    logic [2:0]         us;
  } umag_t;

  typedef struct packed {
    logic [2:0] us;
    logic       zu;
  } uflag_t;

  typedef struct packed {
    logic signed [2:0][31:0] f;
    logic signed [2:0][31:0] p;
  } fp_t;

  // Control and tolerance register.
  logic               busy_q;
  logic [TOL_W-1:0]   tol_q;
  logic [LATENCY-1:0] vld_q;
  logic               accept;

  assign accept      = start_i && !busy_q;
  assign busy_o      = busy_q;
  assign cfg_ready_o = !busy_q;
  assign res_valid_o = vld_q[LATENCY-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      tol_q  <= TOL_RESET;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // ---------------- Stage A: pick world up, form side and forward magnitudes
  logic               xz_small, y_small, z_up, degen;
  logic signed [31:0] fd [3];
  logic [31:0]        tol32;
  nrm_t               a_nrm_d, a_nrm_q;
  fp_t                a_fp_d, a_fp_q;

  always_comb begin
    tol32    = 32'(tol_q);
    xz_small = (mag32(in_i.dir_x) < tol32) && (mag32(in_i.dir_z) < tol32);
    y_small  = mag32(in_i.dir_y) < tol32;
    z_up     = xz_small && !y_small;
    degen    = xz_small && y_small;
    fd[0]    = degen ? 32'sd0 : in_i.dir_x;
    fd[1]    = degen ? 32'sd0 : in_i.dir_y;
    fd[2]    = degen ? $signed(32'(ONE)) : in_i.dir_z;
    for (int i = 0; i < 3; i++) begin
      a_nrm_d.fm[i] = mag32(fd[i]);
      a_nrm_d.fs[i] = fd[i][31];
      a_fp_d.f[i]   = fd[i];
    end
    a_fp_d.p[0] = in_i.pos_x;
    a_fp_d.p[1] = in_i.pos_y;
    a_fp_d.p[2] = in_i.pos_z;
    // Side = F x W: (-fz, 0, fx) for +Y up, (fy, -fx, 0) for +Z up.
    if (z_up) begin
      a_nrm_d.sm[0] = mag32(fd[1]);
      a_nrm_d.ss[0] = fd[1][31];
      a_nrm_d.sm[1] = mag32(fd[0]);
      a_nrm_d.ss[1] = !fd[0][31];
      a_nrm_d.sm[2] = '0;
      a_nrm_d.ss[2] = 1'b0;
    end else begin
      a_nrm_d.sm[0] = mag32(fd[2]);
      a_nrm_d.ss[0] = !fd[2][31];
      a_nrm_d.sm[1] = '0;
      a_nrm_d.ss[1] = 1'b0;
      a_nrm_d.sm[2] = mag32(fd[0]);
      a_nrm_d.ss[2] = fd[0][31];
    end
  end

  always_ff @(posedge clk_i) begin
    a_nrm_q <= a_nrm_d;
    a_fp_q  <= a_fp_d;
  end

  // ---------------- Stages B, C: squares and sums of squares
  logic [2:0][63:0] b_sqs_q, b_sqf_q;
  logic [63:0]      c_sum_s_q, c_sum_f_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      b_sqs_q[i] <= 64'(a_nrm_q.sm[i]) * 64'(a_nrm_q.sm[i]);
      b_sqf_q[i] <= 64'(a_nrm_q.fm[i]) * 64'(a_nrm_q.fm[i]);
    end
    c_sum_s_q <= b_sqs_q[0] + b_sqs_q[1] + b_sqs_q[2];
    c_sum_f_q <= b_sqf_q[0] + b_sqf_q[1] + b_sqf_q[2];
  end

  // Lengths of side and forward.
  logic [31:0] len_s, len_f;

  lvm_isqrt u_sqrt_s (.clk_i(clk_i), .n_i(c_sum_s_q), .r_o(len_s));
  lvm_isqrt u_sqrt_f (.clk_i(clk_i), .n_i(c_sum_f_q), .r_o(len_f));

  // Hold magnitudes and signs while the roots settle.
  nrm_t nrm_dly_q [L_NRM];
  always_ff @(posedge clk_i) begin
    nrm_dly_q[0] <= a_nrm_q;
    for (int i = 1; i < L_NRM; i++) begin
      nrm_dly_q[i] <= nrm_dly_q[i-1];
    end
  end

  // ---------------- Stage E: rounded numerators for the divides
  logic [2:0][NUM_W-1:0] e_num_s_q, e_num_f_q;
  logic [31:0]           e_den_s_q, e_den_f_q;
  sflag_t                e_flag_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e_num_s_q[i] <= (NUM_W'(nrm_dly_q[L_NRM-1].sm[i]) << FRAC_BITS) + NUM_W'(len_s >> 1);
      e_num_f_q[i] <= (NUM_W'(nrm_dly_q[L_NRM-1].fm[i]) << FRAC_BITS) + NUM_W'(len_f >> 1);
    end
    e_den_s_q   <= len_s;
    e_den_f_q   <= len_f;
    e_flag_q.ss <= nrm_dly_q[L_NRM-1].ss;
    e_flag_q.fs <= nrm_dly_q[L_NRM-1].fs;
    e_flag_q.zs <= (len_s == '0);
    e_flag_q.zf <= (len_f == '0);
  end

  logic [2:0][QW-1:0] quo_s, quo_f;

  for (genvar g = 0; g < 3; g++) begin : g_div_sf
    lvm_div u_div_s (.clk_i(clk_i), .num_i(e_num_s_q[g]), .den_i(e_den_s_q), .quo_o(quo_s[g]));
    lvm_div u_div_f (.clk_i(clk_i), .num_i(e_num_f_q[g]), .den_i(e_den_f_q), .quo_o(quo_f[g]));
  end

  sflag_t sflag_dly_q [QW];
  always_ff @(posedge clk_i) begin
    sflag_dly_q[0] <= e_flag_q;
    for (int i = 1; i < QW; i++) begin
      sflag_dly_q[i] <= sflag_dly_q[i-1];
    end
  end

  // ---------------- Stage G: signed unit side and forward
  logic signed [2:0][SW-1:0] g_s_q, g_fn_q;
  sflag_t                    sfl;

  assign sfl = sflag_dly_q[QW-1];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (sfl.zs) begin
        g_s_q[i] <= '0;
      end else begin
        g_s_q[i] <= sfl.ss[i] ? -$signed({1'b0, quo_s[i]}) : $signed({1'b0, quo_s[i]});
      end
      if (sfl.zf) begin
        g_fn_q[i] <= '0;
      end else begin
        g_fn_q[i] <= sfl.fs[i] ? -$signed({1'b0, quo_f[i]}) : $signed({1'b0, quo_f[i]});
      end
    end
  end

  // ---------------- Stage H: cross product terms of side x unit forward
  logic signed [2:0][PW-1:0] h_pa_q, h_pb_q;

  always_ff @(posedge clk_i) begin
    h_pa_q[0] <= PW'($signed(g_s_q[1])) * PW'($signed(g_fn_q[2]));
    h_pb_q[0] <= PW'($signed(g_s_q[2])) * PW'($signed(g_fn_q[1]));
    h_pa_q[1] <= PW'($signed(g_s_q[2])) * PW'($signed(g_fn_q[0]));
    h_pb_q[1] <= PW'($signed(g_s_q[0])) * PW'($signed(g_fn_q[2]));
    h_pa_q[2] <= PW'($signed(g_s_q[0])) * PW'($signed(g_fn_q[1]));
    h_pb_q[2] <= PW'($signed(g_s_q[1])) * PW'($signed(g_fn_q[0]));
  end

  // ---------------- Stage I: round the differences, split sign and magnitude
  logic signed [PW:0]   diff [3];
  logic signed [PW:0]   rsh  [3];
  logic signed [UW-1:0] ur   [3];
  umag_t                i_um_d, i_um_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({h_pa_q[i][PW-1], h_pa_q[i]}) - $signed({h_pb_q[i][PW-1], h_pb_q[i]})
                + $signed((PW + 1)'(HALF));
      rsh[i]  = diff[i] >>> FRAC_BITS;
      ur[i]   = rsh[i][UW-1:0];
      i_um_d.us[i] = ur[i][UW-1];
      i_um_d.um[i] = ur[i][UW-1] ? UW'(-ur[i]) : UW'(ur[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    i_um_q <= i_um_d;
  end

  // ---------------- Stages J, K: length squared of the raw up vector
  logic [2:0][2*UW-1:0] j_sq_q;
  logic [SQRT_W-1:0]    k_sum_q;
  logic [31:0]          len_u;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      j_sq_q[i] <= (2 * UW)'(i_um_q.um[i]) * (2 * UW)'(i_um_q.um[i]);
    end
    k_sum_q <= SQRT_W'(j_sq_q[0]) + SQRT_W'(j_sq_q[1]) + SQRT_W'(j_sq_q[2]);
  end

  lvm_isqrt u_sqrt_u (.clk_i(clk_i), .n_i(k_sum_q), .r_o(len_u));

  umag_t um_dly_q [L_UM];
  always_ff @(posedge clk_i) begin
    um_dly_q[0] <= i_um_q;
    for (int i = 1; i < L_UM; i++) begin
      um_dly_q[i] <= um_dly_q[i-1];
    end
  end

  // ---------------- Stage M: numerators for the up vector
  logic [2:0][NUM_W-1:0] m_num_q;
  logic [31:0]           m_den_q;
  uflag_t                m_flag_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m_num_q[i] <= (NUM_W'(um_dly_q[L_UM-1].um[i]) << FRAC_BITS) + NUM_W'(len_u >> 1);
    end
    m_den_q     <= len_u;
    m_flag_q.us <= um_dly_q[L_UM-1].us;
    m_flag_q.zu <= (len_u == '0);
  end

  logic [2:0][QW-1:0] quo_u;

  for (genvar g = 0; g < 3; g++) begin : g_div_u
    lvm_div u_div_u (.clk_i(clk_i), .num_i(m_num_q[g]), .den_i(m_den_q), .quo_o(quo_u[g]));
  end

  uflag_t uflag_dly_q [QW];
  always_ff @(posedge clk_i) begin
    uflag_dly_q[0] <= m_flag_q;
    for (int i = 1; i < QW; i++) begin
      uflag_dly_q[i] <= uflag_dly_q[i-1];
    end
  end

  // Carry side, forward and position down to the dot products.
  logic signed [2:0][SW-1:0] s_dly_q [L_S];
  fp_t                       fp_dly_q [L_FP];
  always_ff @(posedge clk_i) begin
    s_dly_q[0]  <= g_s_q;
    fp_dly_q[0] <= a_fp_q;
    for (int i = 1; i < L_S; i++) begin
      s_dly_q[i] <= s_dly_q[i-1];
    end
    for (int i = 1; i < L_FP; i++) begin
      fp_dly_q[i] <= fp_dly_q[i-1];
    end
  end

  // ---------------- Stage U: signed unit up vector
  logic signed [2:0][SW-1:0] u_u_q, u_s_q;
  fp_t                       u_fp_q;
  uflag_t                    ufl;

  assign ufl = uflag_dly_q[QW-1];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (ufl.zu) begin
        u_u_q[i] <= '0;
      end else begin
        u_u_q[i] <= ufl.us[i] ? -$signed({1'b0, quo_u[i]}) : $signed({1'b0, quo_u[i]});
      end
    end
    u_s_q  <= s_dly_q[L_S-1];
    u_fp_q <= fp_dly_q[L_FP-1];
  end

  // ---------------- Stage P: products against the position
  localparam int SPW = SW + 32;

  logic signed [2:0][SPW-1:0] p_sp_q, p_up_q;
  logic signed [2:0][63:0]    p_fp_q;
  logic signed [2:0][SW-1:0]  p_s_q, p_u_q;
  logic signed [2:0][31:0]    p_f_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      p_sp_q[i] <= SPW'($signed(u_s_q[i])) * SPW'($signed(u_fp_q.p[i]));
      p_up_q[i] <= SPW'($signed(u_u_q[i])) * SPW'($signed(u_fp_q.p[i]));
      p_fp_q[i] <= 64'($signed(u_fp_q.f[i])) * 64'($signed(u_fp_q.p[i]));
    end
    p_s_q <= u_s_q;
    p_u_q <= u_u_q;
    p_f_q <= u_fp_q.f;
  end

  // ---------------- Stage SUM: exact dot products
  logic signed [DOT_W-1:0]   q_ds_q, q_du_q, q_df_q;
  logic signed [2:0][SW-1:0] q_s_q, q_u_q;
  logic signed [2:0][31:0]   q_f_q;

  always_ff @(posedge clk_i) begin
    q_ds_q <= DOT_W'($signed(p_sp_q[0])) + DOT_W'($signed(p_sp_q[1]))
              + DOT_W'($signed(p_sp_q[2]));
    q_du_q <= DOT_W'($signed(p_up_q[0])) + DOT_W'($signed(p_up_q[1]))
              + DOT_W'($signed(p_up_q[2]));
    q_df_q <= DOT_W'($signed(p_fp_q[0])) + DOT_W'($signed(p_fp_q[1]))
              + DOT_W'($signed(p_fp_q[2]));
    q_s_q  <= p_s_q;
    q_u_q  <= p_u_q;
    q_f_q  <= p_f_q;
  end

  // ---------------- Stage OUT: round half up, negate, saturate
  logic signed [DOT_W-1:0] rnd_s, rnd_u, rnd_f;
  logic signed [31:0]      nf [3];
  lvm_out_t                res_d, res_q;

  always_comb begin
    rnd_s = (q_ds_q + $signed(DOT_W'(HALF))) >>> FRAC_BITS;
    rnd_u = (q_du_q + $signed(DOT_W'(HALF))) >>> FRAC_BITS;
    rnd_f = (q_df_q + $signed(DOT_W'(HALF))) >>> FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      nf[i] = (q_f_q[i] == 32'sh8000_0000) ? 32'sh7fff_ffff : -q_f_q[i];
    end
    res_d.row0_col0  = 32'($signed(q_s_q[0]));
    res_d.row0_col1  = 32'($signed(q_s_q[1]));
    res_d.row0_col2  = 32'($signed(q_s_q[2]));
    res_d.row0_shift = sat32(-rnd_s);
    res_d.row1_col0  = 32'($signed(q_u_q[0]));
    res_d.row1_col1  = 32'($signed(q_u_q[1]));
    res_d.row1_col2  = 32'($signed(q_u_q[2]));
    res_d.row1_shift = sat32(-rnd_u);
    res_d.row2_col0  = nf[0];
    res_d.row2_col1  = nf[1];
    res_d.row2_col2  = nf[2];
    res_d.row2_shift = sat32(rnd_f);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* src/lvm_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps
module lvm_isqrt import lvm_pkg::*; (
  input  logic                  clk_i,
  input  logic [SQRT_W-1:0]     n_i,
  output logic [SQRT_W/2-1:0]   r_o
);

  logic [SQRT_W-1:0] n_q   [SQRT_STAGES];
  logic [SQRT_W-1:0] r_q   [SQRT_STAGES];
  logic [SQRT_W-1:0] n_in  [SQRT_STAGES];
  logic [SQRT_W-1:0] r_in  [SQRT_STAGES];
  logic [SQRT_W-1:0] bitv  [SQRT_STAGES];

  // Chain each stage to the previous one; the trial bit walks down two places a stage.
  always_comb begin
    n_in[0] = n_i;
    r_in[0] = '0;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      n_in[i] = n_q[i-1];
      r_in[i] = r_q[i-1];
    end
    for (int i = 0; i < SQRT_STAGES; i++) begin
      bitv[i] = SQRT_W'(1) << (SQRT_W - 2 - 2 * i);
    end
  end

  // Try the bit, keep it when the remainder allows.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SQRT_STAGES; i++) begin
      if (n_in[i] >= r_in[i] + bitv[i]) begin
        n_q[i] <= n_in[i] - (r_in[i] + bitv[i]);
        r_q[i] <= (r_in[i] >> 1) + bitv[i];
      end else begin
        n_q[i] <= n_in[i];
        r_q[i] <= r_in[i] >> 1;
      end
    end
  end

  assign r_o = r_q[SQRT_STAGES-1][SQRT_W/2-1:0];

endmodule

/* src/lvm_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module lvm_div import lvm_pkg::*; (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [31:0]      den_i,
  output logic [QW-1:0]    quo_o
);

  localparam int CW = NUM_W + QW;

  logic [NUM_W-1:0] rem_q  [QW];
  logic [31:0]      den_q  [QW];
  logic [QW-1:0]    quo_q  [QW];
  logic [NUM_W-1:0] rem_in [QW];
  logic [31:0]      den_in [QW];
  logic [QW-1:0]    quo_in [QW];
  logic [CW-1:0]    trial  [QW];

  // Chain stages; stage i decides quotient bit QW-1-i.
  always_comb begin
    rem_in[0] = num_i;
    den_in[0] = den_i;
    quo_in[0] = '0;
    for (int i = 1; i < QW; i++) begin
      rem_in[i] = rem_q[i-1];
      den_in[i] = den_q[i-1];
      quo_in[i] = quo_q[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      trial[i] = CW'(den_in[i]) << (QW - 1 - i);
    end
  end

  // Subtract the shifted divisor when it fits.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QW; i++) begin
      den_q[i] <= den_in[i];
      if (CW'(rem_in[i]) >= trial[i]) begin
        rem_q[i] <= rem_in[i] - trial[i][NUM_W-1:0];
        quo_q[i] <= quo_in[i] | (QW'(1) << (QW - 1 - i));
      end else begin
        rem_q[i] <= rem_in[i];
        quo_q[i] <= quo_in[i];
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

/* src/lvm_checker.sv */
// Port-level checks for the look-at view matrix unit, bound to the top level.
`timescale 1ns / 1ps
`include "lookat_view_matrix_assert.svh"
module lvm_checker import lvm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     res_valid_o,
  input lvm_out_t res_o,
  input logic     cfg_ready_o
);

  // Every accepted beat yields its result after the fixed latency.
  `LVM_ASSERT(a_start_to_result, clk_i, rst_ni, (start_i && !busy_o) |-> ##LATENCY res_valid_o)

  // No result appears without a beat accepted the latency before.
  `LVM_ASSERT(a_result_has_start, clk_i, rst_ni, res_valid_o |-> $past(start_i && !busy_o, LATENCY))

  // The side vector is perpendicular to the chosen world-up axis.
  `LVM_ASSERT(a_side_axis_zero, clk_i, rst_ni, res_valid_o |-> (res_o.row0_col1 == '0 || res_o.row0_col2 == '0))

  // Configuration is open exactly when starts are.
  `LVM_ASSERT_ALWAYS(a_cfg_ready_busy, clk_i, cfg_ready_o === !busy_o)

endmodule

bind lookat_view_matrix lvm_checker u_lvm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o),
  .cfg_ready_o (cfg_ready_o)
);

/* tb/sv/tb_lookat_view_matrix.sv */
// Testbench for the look-at view matrix unit: checks every camera's rows against a predictor.
`timescale 1ns / 1ps
module tb_lookat_view_matrix;
  import lvm_pkg::*;

  localparam longint UNIT = 64'sd1 << FRAC_BITS;
  localparam longint HALF_UNIT = 64'sd1 << (FRAC_BITS - 1);
  localparam int MAX_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  lvm_in_t in_i = '0;
  logic res_valid_o;
  lvm_out_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [TOL_W-1:0] cfg_data_i = '0;

  lookat_view_matrix uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .in_i(in_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Camera beats waiting to be driven; a tol_write entry carries a tolerance instead.
  typedef struct {
    bit       tol_write;
    bit       drain;
    bit [15:0] tol;
    lvm_in_t  cam;
  } cam_job_t;

  cam_job_t pending_cams[$];
  lvm_out_t expected_rows[$];
  bit [15:0] tol_model = 16'd7;
  int errors = 0;
  int cycle_cnt = 0;
  bit stim_done = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint fdiv(longint x);
    if (x >= 0) return x >>> FRAC_BITS;
    return -(((-x) + UNIT - 1) >>> FRAC_BITS);
  endfunction

  function automatic longint rnd(longint x);
    return fdiv(x + HALF_UNIT);
  endfunction

  function automatic longint labs(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic bit [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale a vector to unit length, rounding halves away from zero.
  function automatic void unitize(input longint c[3], output longint o[3]);
    longint unsigned sum, len, a, q;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      a = labs(c[i]);
      sum += a * a;
    end
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        o[i] = 0;
      end else begin
        q = (longint'(labs(c[i])) * UNIT + len / 2) / len;
        o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic longint dot_round(longint a[3], longint b[3]);
    longint sq, sr, p, q;
    sq = 0;
    sr = 0;
    for (int i = 0; i < 3; i++) begin
      p = a[i] * b[i];
      q = fdiv(p);
      sq += q;
      sr += p - q * UNIT;
    end
    return sq + fdiv(sr + HALF_UNIT);
  endfunction

  function automatic lvm_out_t predict_rows(lvm_in_t c, bit [15:0] tol);
    longint p[3], f[3], w[3], sr[3], s[3], fn[3], ur[3], u[3];
    longint t;
    lvm_out_t r;
    t = tol;
    p = '{longint'(c.pos_x), longint'(c.pos_y), longint'(c.pos_z)};
    f = '{longint'(c.dir_x), longint'(c.dir_y), longint'(c.dir_z)};
    w = '{0, 1, 0};
    // Near-vertical direction: pick +Z as world up, or fall back to a +Z forward direction.
    if (labs(f[0]) < t && labs(f[2]) < t) begin
      if (!(labs(f[1]) < t)) begin
        w = '{0, 0, 1};
      end else begin
        f = '{0, 0, UNIT};
      end
    end
    sr[0] = f[1] * w[2] - f[2] * w[1];
    sr[1] = f[2] * w[0] - f[0] * w[2];
    sr[2] = f[0] * w[1] - f[1] * w[0];
    unitize(sr, s);
    unitize(f, fn);
    ur[0] = rnd(s[1] * fn[2] - s[2] * fn[1]);
    ur[1] = rnd(s[2] * fn[0] - s[0] * fn[2]);
    ur[2] = rnd(s[0] * fn[1] - s[1] * fn[0]);
    unitize(ur, u);
    r.row0_col0 = clamp32(s[0]);
    r.row0_col1 = clamp32(s[1]);
    r.row0_col2 = clamp32(s[2]);
    r.row0_shift = clamp32(-dot_round(s, p));
    r.row1_col0 = clamp32(u[0]);
    r.row1_col1 = clamp32(u[1]);
    r.row1_col2 = clamp32(u[2]);
    r.row1_shift = clamp32(-dot_round(u, p));
    r.row2_col0 = clamp32(-f[0]);
    r.row2_col1 = clamp32(-f[1]);
    r.row2_col2 = clamp32(-f[2]);
    r.row2_shift = clamp32(dot_round(f, p));
    return r;
  endfunction

  // Mostly modest values, sometimes a full-range or extreme one.
  function automatic logic [31:0] rand_comp(bit [15:0] tol);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 2 * tol + 2)) - int'(tol) - 1);
      3: return 32'(int'($urandom_range(0, 2 * 65536)) - 65536);
      default: return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  task automatic add_cam(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    cam_job_t j;
    j.tol_write = 0;
    j.drain = 0;
    j.tol = 0;
    j.cam = '{px, py, pz, dx, dy, dz};
    pending_cams.push_back(j);
  endtask

  task automatic add_tol(bit [15:0] v);
    cam_job_t j;
    j.tol_write = 1;
    j.drain = 1;
    j.tol = v;
    j.cam = '0;
    pending_cams.push_back(j);
  endtask

  // Driver: one beat per queue entry, random gaps, tolerance writes only when drained.
  int gap = 0;
  int settle = 0;
  bit [15:0] drv_tol = 16'd7;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_valid_i <= 1'b0;
      end else if (start_i && !busy_o) begin
        expected_rows.push_back(predict_rows(in_i, drv_tol));
        pending_cams.pop_front();
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap != 0 || pending_cams.size() == 0 || pending_cams[0].drain)
          start_i <= 1'b0;
        else
          in_i <= pending_cams[0].cam;
      end else if (!start_i && !cfg_valid_i) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_cams.size() == 0) begin
          stim_done <= 1'b1;
        end else if (pending_cams[0].drain) begin
          // Hold until every result is back and the pipeline has gone quiet.
          if (expected_rows.size() != 0) begin
            settle = 0;
          end else if (settle < LATENCY + 8) begin
            settle++;
          end else begin
            settle = 0;
            if (pending_cams[0].tol_write) begin
              drv_tol = pending_cams[0].tol;
              cfg_data_i <= pending_cams[0].tol;
              cfg_valid_i <= 1'b1;
            end
            pending_cams.pop_front();
          end
        end else begin
          in_i <= pending_cams[0].cam;
          start_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk_i) begin
    lvm_out_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = expected_rows.pop_front();
        if (res_o.row0_col0 !== e.row0_col0)
          begin $error("row0_col0 exp %0d got %0d", e.row0_col0, res_o.row0_col0); errors++; end
        if (res_o.row0_col1 !== e.row0_col1)
          begin $error("row0_col1 exp %0d got %0d", e.row0_col1, res_o.row0_col1); errors++; end
        if (res_o.row0_col2 !== e.row0_col2)
          begin $error("row0_col2 exp %0d got %0d", e.row0_col2, res_o.row0_col2); errors++; end
        if (res_o.row0_shift !== e.row0_shift)
          begin $error("row0_shift exp %0d got %0d", e.row0_shift, res_o.row0_shift); errors++; end
        if (res_o.row1_col0 !== e.row1_col0)
          begin $error("row1_col0 exp %0d got %0d", e.row1_col0, res_o.row1_col0); errors++; end
        if (res_o.row1_col1 !== e.row1_col1)
          begin $error("row1_col1 exp %0d got %0d", e.row1_col1, res_o.row1_col1); errors++; end
        if (res_o.row1_col2 !== e.row1_col2)
          begin $error("row1_col2 exp %0d got %0d", e.row1_col2, res_o.row1_col2); errors++; end
        if (res_o.row1_shift !== e.row1_shift)
          begin $error("row1_shift exp %0d got %0d", e.row1_shift, res_o.row1_shift); errors++; end
        if (res_o.row2_col0 !== e.row2_col0)
          begin $error("row2_col0 exp %0d got %0d", e.row2_col0, res_o.row2_col0); errors++; end
        if (res_o.row2_col1 !== e.row2_col1)
          begin $error("row2_col1 exp %0d got %0d", e.row2_col1, res_o.row2_col1); errors++; end
        if (res_o.row2_col2 !== e.row2_col2)
          begin $error("row2_col2 exp %0d got %0d", e.row2_col2, res_o.row2_col2); errors++; end
        if (res_o.row2_shift !== e.row2_shift)
          begin $error("row2_shift exp %0d got %0d", e.row2_shift, res_o.row2_shift); errors++; end
      end
    end
  end

  // Fill the stimulus queue, release reset, then wait for the drain or the limit.
  initial begin
    bit [15:0] tols[4];
    bit [15:0] t;
    tols = '{16'd0, 16'hffff, 16'd7, 16'd300};
    // Directed: default tolerance, then each corner of the degenerate handling.
    add_cam(0, 0, 0, 0, 0, 32'h0001_0000);
    add_cam(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000);
    add_cam(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff);
    add_cam(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 32'h0001_0000, 0);
    add_cam(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 32'hffff_0000, 3);
    add_cam(32'h0005_0000, 0, 0, 0, 0, 0);
    add_cam(32'h0005_0000, 1, 0, 6, 6, 6);
    add_cam(32'hffff_ffff, 0, 32'h1234_5678, 7, 1, 32'hffff_fff9);
    add_cam(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h8000_0000);
    add_cam(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 0);
    add_tol(16'd0);
    add_cam(0, 0, 0, 0, 0, 0);
    add_cam(1, 2, 3, 0, 32'h0003_0000, 0);
    add_cam(1, 2, 3, 1, 0, 0);
    add_tol(16'hffff);
    add_cam(32'h0001_0000, 0, 0, 32'h0000_fffe, 32'h8000_0000, 32'hffff_0002);
    add_cam(32'h0001_0000, 0, 0, 32'h0000_fffe, 32'h0000_fffe, 32'h0001_0000);
    add_cam(32'h0001_0000, 0, 0, 32'h0000_ffff, 32'h0000_ffff, 32'hffff_0001);
    // Random phases across several tolerances; one extra drain in the middle of each phase.
    for (int ph = 0; ph < 8; ph++) begin
      t = ph < 4 ? tols[ph] : 16'($urandom());
      add_tol(t);
      for (int k = 0; k < 50; k++) begin
        if (k == 25) add_tol(t);
        add_cam(rand_comp(t), rand_comp(t), rand_comp(t),
                rand_comp(t), rand_comp(t), rand_comp(t));
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_rows.size() == 0 || cycle_cnt >= MAX_CYCLES);
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end else begin
      repeat (LATENCY + 10) @(posedge clk_i);
      if (errors == 0 && expected_rows.size() == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
      $finish;
    end
  end

endmodule
